// ===== rtl/barometer_trim_compensation_unit_defines.svh =====
// assertion macros for the barometer trim compensation unit
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef BAROMETER_TRIM_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETER_TRIM_COMPENSATION_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define BTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btc: same-cycle check failed");

// condition holds in the following cycle
`define BTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btc: next-cycle check failed");

`endif

// ===== rtl/btc_pkg.sv =====
// shared types, op codes and micro program for the trim compensation unit
// no dependencies
package btc_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned RawW   = 20;
    localparam int unsigned OutW   = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned PcW    = 6;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_TEMP_TRIM  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_MID  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_SHL  = 4'd2;
    localparam logic [3:0] OP_ASR  = 4'd3;
    localparam logic [3:0] OP_SX32 = 4'd4;
    localparam logic [3:0] OP_MUL  = 4'd5;
    localparam logic [3:0] OP_DIV  = 4'd6;
    localparam logic [3:0] OP_SETF = 4'd7;
    localparam logic [3:0] OP_CHKZ = 4'd8;
    localparam logic [3:0] OP_END  = 4'd9;

    // operand sources
    localparam logic [4:0] S_R0 = 5'd0;
    localparam logic [4:0] S_R1 = 5'd1;
    localparam logic [4:0] S_R2 = 5'd2;
    localparam logic [4:0] S_R3 = 5'd3;
    localparam logic [4:0] S_R4 = 5'd4;
    localparam logic [4:0] S_R5 = 5'd5;
    localparam logic [4:0] S_ADC = 5'd6;
    localparam logic [4:0] S_FINE = 5'd7;
    localparam logic [4:0] S_T1 = 5'd8;
    localparam logic [4:0] S_T2 = 5'd9;
    localparam logic [4:0] S_T3 = 5'd10;
    localparam logic [4:0] S_P1 = 5'd11;
    localparam logic [4:0] S_P2 = 5'd12;
    localparam logic [4:0] S_P3 = 5'd13;
    localparam logic [4:0] S_P4 = 5'd14;
    localparam logic [4:0] S_P5 = 5'd15;
    localparam logic [4:0] S_P6 = 5'd16;
    localparam logic [4:0] S_P7 = 5'd17;
    localparam logic [4:0] S_P8 = 5'd18;
    localparam logic [4:0] S_P9 = 5'd19;
    localparam logic [4:0] S_C128000 = 5'd20;
    localparam logic [4:0] S_C1048576 = 5'd21;
    localparam logic [4:0] S_C3125 = 5'd22;
    localparam logic [4:0] S_C128 = 5'd23;
    localparam logic [4:0] S_C5 = 5'd24;
    localparam logic [4:0] S_ONE = 5'd25;

    localparam logic [2:0] D_R0 = 3'd0;
    localparam logic [2:0] D_R1 = 3'd1;
    localparam logic [2:0] D_R2 = 3'd2;
    localparam logic [2:0] D_R3 = 3'd3;
    localparam logic [2:0] D_R4 = 3'd4;
    localparam logic [2:0] D_R5 = 3'd5;

    localparam logic [PcW-1:0] PC_TEMP  = 6'd0;
    localparam logic [PcW-1:0] PC_PRESS = 6'd24;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
        logic [5:0] imm;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic start;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic zero;
        logic out_full;
    } t_dp_status;

    function automatic t_uop f_u(logic [3:0] op, logic [2:0] dst, logic [4:0] sa,
                                 logic [4:0] sb, logic [5:0] imm);
        t_uop u;
        u.op = op;
        u.dst = dst;
        u.sa = sa;
        u.sb = sb;
        u.imm = imm;
        return u;
    endfunction

    // micro program: temperature from PC_TEMP, pressure from PC_PRESS
    function automatic t_uop f_rom(logic [PcW-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = f_u(OP_ASR, D_R0, S_ADC, S_R0, 6'd3);
            6'd1:  u = f_u(OP_SHL, D_R1, S_T1, S_R0, 6'd1);
            6'd2:  u = f_u(OP_SUB, D_R0, S_R0, S_R1, 6'd0);
            6'd3:  u = f_u(OP_ASR, D_R1, S_ADC, S_R0, 6'd4);
            6'd4:  u = f_u(OP_SUB, D_R1, S_R1, S_T1, 6'd0);
            6'd5:  u = f_u(OP_MUL, D_R0, S_R0, S_T2, 6'd0);
            6'd6:  u = f_u(OP_SX32, D_R0, S_R0, S_R0, 6'd0);
            6'd7:  u = f_u(OP_ASR, D_R0, S_R0, S_R0, 6'd11);
            6'd8:  u = f_u(OP_MUL, D_R1, S_R1, S_R1, 6'd0);
            6'd9:  u = f_u(OP_SX32, D_R1, S_R1, S_R0, 6'd0);
            6'd10: u = f_u(OP_ASR, D_R1, S_R1, S_R0, 6'd12);
            6'd11: u = f_u(OP_MUL, D_R1, S_R1, S_T3, 6'd0);
            6'd12: u = f_u(OP_SX32, D_R1, S_R1, S_R0, 6'd0);
            6'd13: u = f_u(OP_ASR, D_R1, S_R1, S_R0, 6'd14);
            6'd14: u = f_u(OP_ADD, D_R0, S_R0, S_R1, 6'd0);
            6'd15: u = f_u(OP_SX32, D_R0, S_R0, S_R0, 6'd0);
            6'd16: u = f_u(OP_SETF, D_R0, S_R0, S_R0, 6'd0);
            6'd17: u = f_u(OP_MUL, D_R1, S_R0, S_C5, 6'd0);
            6'd18: u = f_u(OP_ADD, D_R1, S_R1, S_C128, 6'd0);
            6'd19: u = f_u(OP_SX32, D_R1, S_R1, S_R0, 6'd0);
            6'd20: u = f_u(OP_ASR, D_R1, S_R1, S_R0, 6'd8);
            6'd21: u = f_u(OP_END, D_R0, S_R0, S_R0, 6'd0);
            6'd24: u = f_u(OP_SUB, D_R0, S_FINE, S_C128000, 6'd0);
            6'd25: u = f_u(OP_MUL, D_R1, S_R0, S_R0, 6'd0);
            6'd26: u = f_u(OP_MUL, D_R2, S_R1, S_P6, 6'd0);
            6'd27: u = f_u(OP_MUL, D_R3, S_R0, S_P5, 6'd0);
            6'd28: u = f_u(OP_SHL, D_R3, S_R3, S_R0, 6'd17);
            6'd29: u = f_u(OP_ADD, D_R2, S_R2, S_R3, 6'd0);
            6'd30: u = f_u(OP_SHL, D_R3, S_P4, S_R0, 6'd35);
            6'd31: u = f_u(OP_ADD, D_R2, S_R2, S_R3, 6'd0);
            6'd32: u = f_u(OP_MUL, D_R1, S_R1, S_P3, 6'd0);
            6'd33: u = f_u(OP_ASR, D_R1, S_R1, S_R0, 6'd8);
            6'd34: u = f_u(OP_MUL, D_R3, S_R0, S_P2, 6'd0);
            6'd35: u = f_u(OP_SHL, D_R3, S_R3, S_R0, 6'd12);
            6'd36: u = f_u(OP_ADD, D_R1, S_R1, S_R3, 6'd0);
            6'd37: u = f_u(OP_SHL, D_R3, S_ONE, S_R0, 6'd47);
            6'd38: u = f_u(OP_ADD, D_R1, S_R3, S_R1, 6'd0);
            6'd39: u = f_u(OP_MUL, D_R1, S_R1, S_P1, 6'd0);
            6'd40: u = f_u(OP_ASR, D_R1, S_R1, S_R0, 6'd33);
            6'd41: u = f_u(OP_CHKZ, D_R0, S_R1, S_R0, 6'd0);
            6'd42: u = f_u(OP_SUB, D_R0, S_C1048576, S_ADC, 6'd0);
            6'd43: u = f_u(OP_SHL, D_R0, S_R0, S_R0, 6'd31);
            6'd44: u = f_u(OP_SUB, D_R0, S_R0, S_R2, 6'd0);
            6'd45: u = f_u(OP_MUL, D_R0, S_R0, S_C3125, 6'd0);
            6'd46: u = f_u(OP_DIV, D_R0, S_R0, S_R1, 6'd0);
            6'd47: u = f_u(OP_ASR, D_R3, S_R0, S_R0, 6'd13);
            6'd48: u = f_u(OP_MUL, D_R4, S_P9, S_R3, 6'd0);
            6'd49: u = f_u(OP_MUL, D_R4, S_R4, S_R3, 6'd0);
            6'd50: u = f_u(OP_ASR, D_R4, S_R4, S_R0, 6'd25);
            6'd51: u = f_u(OP_MUL, D_R5, S_P8, S_R0, 6'd0);
            6'd52: u = f_u(OP_ASR, D_R5, S_R5, S_R0, 6'd19);
            6'd53: u = f_u(OP_ADD, D_R0, S_R0, S_R4, 6'd0);
            6'd54: u = f_u(OP_ADD, D_R0, S_R0, S_R5, 6'd0);
            6'd55: u = f_u(OP_ASR, D_R0, S_R0, S_R0, 6'd8);
            6'd56: u = f_u(OP_SHL, D_R3, S_P7, S_R0, 6'd4);
            6'd57: u = f_u(OP_ADD, D_R0, S_R0, S_R3, 6'd0);
            6'd58: u = f_u(OP_END, D_R0, S_R0, S_R0, 6'd0);
            default: u = f_u(OP_END, D_R0, S_R0, S_R0, 6'd0);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/btc_if.sv =====
// stream and configuration channel interfaces for the trim compensation unit
// depends on btc_pkg
interface btc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [btc_pkg::RawW-1:0]    raw_sample;
    modport source (output valid, kind, raw_sample, input ready);
    modport sink (input valid, kind, raw_sample, output ready);
endinterface

interface btc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic signed [btc_pkg::OutW-1:0] temperature_centi;
    logic [btc_pkg::OutW-1:0]    pressure_q24_8;
    logic                        zero_divisor;
    modport source (output valid, result_kind, temperature_centi, pressure_q24_8,
                    zero_divisor, input ready);
    modport sink (input valid, result_kind, temperature_centi, pressure_q24_8,
                  zero_divisor, output ready);
endinterface

interface btc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [btc_pkg::CfgIdxW-1:0]   index;
    logic [btc_pkg::DataW-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/btc_ctrl.sv =====
// sequencer: steps through the micro program and issues datapath commands
// depends on btc_pkg
module btc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_kind,
    output logic                o_in_ready,
    input  btc_pkg::t_dp_status i_status,
    output btc_pkg::t_dp_cmd    o_cmd
);
    import btc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [PcW-1:0] r_pc, n_pc;
    t_uop           w_uop;
    logic           w_emits;

    assign w_uop = f_rom(r_pc);
    assign w_emits = (w_uop.op == OP_END) || (w_uop.op == OP_CHKZ);

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        o_in_ready = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.uop = w_uop;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_pc = i_in_kind ? PC_PRESS : PC_TEMP;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // result register must be free before anything is emitted
                if (!(w_emits && i_status.out_full)) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    if (w_uop.op == OP_END ||
                        (w_uop.op == OP_CHKZ && i_status.zero)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pc = r_pc + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/btc_datapath.sv =====
// trim registers, scratch registers, shared 32x32 multiplier, serial divider
// and the result register; depends on btc_pkg
module btc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btc_pkg::t_dp_cmd              i_cmd,
    output btc_pkg::t_dp_status           o_status,
    input  logic                          i_in_kind,
    input  logic [btc_pkg::RawW-1:0]      i_in_raw_sample,
    input  logic                          i_cfg_we,
    input  logic [btc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [btc_pkg::DataW-1:0]     i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic signed [btc_pkg::OutW-1:0] o_temperature_centi,
    output logic [btc_pkg::OutW-1:0]      o_pressure_q24_8,
    output logic                          o_zero_divisor
);
    import btc_pkg::*;

    logic [47:0]       r_temp_trim;
    logic [63:0]       r_press_low, r_press_mid;
    logic [15:0]       r_press_high;
    logic [31:0]       r_fine;
    logic              r_kind;
    logic [RawW-1:0]   r_raw;
    logic [63:0]       r_r0, r_r1, r_r2, r_r3, r_r4, r_r5;
    logic              r_busy;
    logic [3:0]        r_op;
    logic [2:0]        r_dst;
    logic [5:0]        r_imm;
    logic [63:0]       r_a, r_b, r_acc, r_prod;
    logic [6:0]        r_cnt;
    logic              r_neg;
    logic              r_out_valid;
    logic              r_out_kind, r_out_zero;
    logic [31:0]       r_out_temp, r_out_press;

    logic [63:0] w_src_a, w_src_b;
    logic [63:0] w_alu;
    logic [31:0] w_mx, w_my;
    logic [63:0] w_mprod;
    logic [63:0] w_shrem;
    logic [64:0] w_trial;
    logic        w_done;
    logic [63:0] w_wdata;
    logic        w_we;
    logic [31:0] w_sat;

    function automatic logic [63:0] f_s16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] f_src(
        logic [4:0] sel, logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
        logic [63:0] r3, logic [63:0] r4, logic [63:0] r5, logic [RawW-1:0] raw,
        logic [31:0] fine, logic [47:0] tt, logic [63:0] pl, logic [63:0] pm,
        logic [15:0] ph);
        logic [63:0] v;
        case (sel)
            S_R0: v = r0;
            S_R1: v = r1;
            S_R2: v = r2;
            S_R3: v = r3;
            S_R4: v = r4;
            S_R5: v = r5;
            S_ADC: v = {{(64-RawW){1'b0}}, raw};
            S_FINE: v = {{32{fine[31]}}, fine};
            S_T1: v = {48'd0, tt[15:0]};
            S_T2: v = f_s16(tt[31:16]);
            S_T3: v = f_s16(tt[47:32]);
            S_P1: v = {48'd0, pl[15:0]};
            S_P2: v = f_s16(pl[31:16]);
            S_P3: v = f_s16(pl[47:32]);
            S_P4: v = f_s16(pl[63:48]);
            S_P5: v = f_s16(pm[15:0]);
            S_P6: v = f_s16(pm[31:16]);
            S_P7: v = f_s16(pm[47:32]);
            S_P8: v = f_s16(pm[63:48]);
            S_P9: v = f_s16(ph);
            S_C128000: v = 64'd128000;
            S_C1048576: v = 64'd1048576;
            S_C3125: v = 64'd3125;
            S_C128: v = 64'd128;
            S_C5: v = 64'd5;
            S_ONE: v = 64'd1;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    assign w_src_a = f_src(i_cmd.uop.sa, r_r0, r_r1, r_r2, r_r3, r_r4, r_r5, r_raw,
                           r_fine, r_temp_trim, r_press_low, r_press_mid, r_press_high);
    assign w_src_b = f_src(i_cmd.uop.sb, r_r0, r_r1, r_r2, r_r3, r_r4, r_r5, r_raw,
                           r_fine, r_temp_trim, r_press_low, r_press_mid, r_press_high);

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_a + r_b;
            OP_SUB:  w_alu = r_a - r_b;
            OP_SHL:  w_alu = r_a << r_imm;
            OP_ASR:  w_alu = 64'($signed(r_a) >>> r_imm);
            OP_SX32: w_alu = {{32{r_a[31]}}, r_a[31:0]};
            default: w_alu = r_a;
        endcase
    end

    // partial products: lo*lo, lo*hi, hi*lo; the hi*hi term wraps away
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_mx = r_a[31:0];
                w_my = r_b[31:0];
            end
            2'd1: begin
                w_mx = r_a[31:0];
                w_my = r_b[63:32];
            end
            default: begin
                w_mx = r_a[63:32];
                w_my = r_b[31:0];
            end
        endcase
    end
    assign w_mprod = {32'd0, w_mx} * {32'd0, w_my};

    // restoring divide step on magnitudes
    assign w_shrem = {r_acc[62:0], r_a[63]};
    assign w_trial = {1'b0, w_shrem} - {1'b0, r_b};

    assign w_sat = r_r0[63] ? 32'd0 :
                   (r_r0[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_r0[31:0];

    always_comb begin
        w_done = 1'b0;
        w_we = 1'b0;
        w_wdata = w_alu;
        if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    w_wdata = r_acc + {r_prod[31:0], 32'd0};
                    if (r_cnt == 7'd3) begin
                        w_done = 1'b1;
                        w_we = 1'b1;
                    end
                end
                OP_DIV: begin
                    w_wdata = r_neg ? (64'd0 - r_a) : r_a;
                    if (r_cnt == 7'd65) begin
                        w_done = 1'b1;
                        w_we = 1'b1;
                    end
                end
                OP_SETF, OP_CHKZ, OP_END: w_done = 1'b1;
                default: begin
                    w_done = 1'b1;
                    w_we = 1'b1;
                end
            endcase
        end
    end

    assign o_status.done = w_done;
    assign o_status.zero = (r_a == 64'd0);
    assign o_status.out_full = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_press_low <= '0;
            r_press_mid <= '0;
            r_press_high <= '0;
            r_fine <= '0;
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEMP_TRIM:  r_temp_trim <= i_cfg_data[47:0];
                    CFG_PRESS_LOW:  r_press_low <= i_cfg_data;
                    CFG_PRESS_MID:  r_press_mid <= i_cfg_data;
                    CFG_PRESS_HIGH: r_press_high <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (r_busy && r_op == OP_SETF) begin
                r_fine <= r_a[31:0];
            end
            if (r_busy && r_op == OP_END) begin
                r_out_valid <= 1'b1;
            end
            if (r_busy && r_op == OP_CHKZ && r_a == 64'd0) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_in_kind;
            r_raw <= i_in_raw_sample;
        end
        if (i_cmd.start) begin
            r_op <= i_cmd.uop.op;
            r_dst <= i_cmd.uop.dst;
            r_imm <= i_cmd.uop.imm;
            r_a <= w_src_a;
            r_b <= w_src_b;
            r_cnt <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_op == OP_MUL) begin
                r_prod <= w_mprod;
                if (r_cnt == 7'd1) begin
                    r_acc <= r_prod;
                end else if (r_cnt == 7'd2) begin
                    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                end
            end
            if (r_op == OP_DIV) begin
                if (r_cnt == 7'd0) begin
                    r_neg <= r_a[63] ^ r_b[63];
                    r_a <= r_a[63] ? (64'd0 - r_a) : r_a;
                    r_b <= r_b[63] ? (64'd0 - r_b) : r_b;
                    r_acc <= '0;
                end else if (r_cnt <= 7'd64) begin
                    if (!w_trial[64]) begin
                        r_acc <= w_trial[63:0];
                        r_a <= {r_a[62:0], 1'b1};
                    end else begin
                        r_acc <= w_shrem;
                        r_a <= {r_a[62:0], 1'b0};
                    end
                end
            end
        end
        if (w_we) begin
            case (r_dst)
                D_R0: r_r0 <= w_wdata;
                D_R1: r_r1 <= w_wdata;
                D_R2: r_r2 <= w_wdata;
                D_R3: r_r3 <= w_wdata;
                D_R4: r_r4 <= w_wdata;
                D_R5: r_r5 <= w_wdata;
                default: ;
            endcase
        end
        if (r_busy && r_op == OP_END) begin
            r_out_kind <= r_kind;
            r_out_zero <= 1'b0;
            r_out_temp <= r_kind ? 32'd0 : r_r1[31:0];
            r_out_press <= r_kind ? w_sat : 32'd0;
        end
        if (r_busy && r_op == OP_CHKZ && r_a == 64'd0) begin
            r_out_kind <= r_kind;
            r_out_zero <= 1'b1;
            r_out_temp <= 32'd0;
            r_out_press <= 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_q24_8 = r_out_press;
    assign o_zero_divisor = r_out_zero;

endmodule

// ===== rtl/barometer_trim_compensation_unit.sv =====
// Barometric trim compensation unit, top level.
// Input channel i_in: kind (0 temperature, 1 pressure) and a raw 20-bit sample.
// Output channel o_res: one result per item with kind, temperature in 0.01 degC,
// pressure in Pa as Q24.8 and the zero divisor flag.
// Config channel i_cfg: index 0 temp trim, 1..3 pressure trim words; always
// ready, write only while no item is in flight.
// Items are worked one at a time by a micro-programmed sequencer over a 64-bit
// datapath with one 32x32 multiplier and a one-bit-per-cycle divider. Each
// step is issued and then executed; a 64-bit product sums three partial products.
// The input is ready again in the cycle after the result is written, so a new
// item is not taken before the last one is through.
// While a result waits in the result register the next item is taken and worked
// up to its first step that emits a result (the end, or the zero divisor check
// for pressure); the input then stays blocked until the receiver takes the result.
// Reset clears the trim registers and the fine temperature to zero.
// depends on btc_pkg, btc_if, btc_ctrl, btc_datapath and the defines header
`include "barometer_trim_compensation_unit_defines.svh"

module barometer_trim_compensation_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    btc_in_if.sink    i_in,
    btc_out_if.source o_res,
    btc_cfg_if.sink   i_cfg
);
    import btc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    btc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    btc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_in_kind           (i_in.kind),
        .i_in_raw_sample     (i_in.raw_sample),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .o_out_valid         (o_res.valid),
        .i_out_ready         (o_res.ready),
        .o_result_kind       (o_res.result_kind),
        .o_temperature_centi (o_res.temperature_centi),
        .o_pressure_q24_8    (o_res.pressure_q24_8),
        .o_zero_divisor      (o_res.zero_divisor)
    );

    `BTC_ASSERT_NOW(a_zero_div_press, o_res.valid && o_res.zero_divisor, o_res.result_kind && (o_res.pressure_q24_8 == 32'd0))
    `BTC_ASSERT_NOW(a_temp_clean, o_res.valid && !o_res.result_kind, (o_res.pressure_q24_8 == 32'd0) && !o_res.zero_divisor)
    `BTC_ASSERT_NEXT(a_one_in_flight, i_in.valid && i_in.ready, !i_in.ready)
    `BTC_ASSERT_NOW(a_no_start_busy, w_cmd.start, !w_status.done)

endmodule

// ===== tb/btc_tb_if.sv =====
// testbench-side view of the trim compensation unit channels
// the channel interfaces themselves come from rtl/btc_if.sv; this file only
// holds one typed result record used by the testbench top
package btc_tb_pkg;
    import btc_pkg::*;

    typedef struct {
        logic                     kind;
        logic signed [OutW-1:0]   temperature_centi;
        logic [OutW-1:0]          pressure_q24_8;
        logic                     zero_divisor;
    } t_btc_result;
endpackage

// ===== tb/barometer_trim_compensation_unit_tb.sv =====
// testbench for barometer_trim_compensation_unit: directed and random samples
// checked against a behavioral model of the trim arithmetic
// depends on btc_pkg, btc_if, btc_tb_pkg and the unit's rtl
module barometer_trim_compensation_unit_tb;
    import btc_pkg::*;
    import btc_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic i_clk;
    logic i_rst_n;

    btc_in_if  in_ch ();
    btc_out_if res_ch ();
    btc_cfg_if cfg_ch ();

    barometer_trim_compensation_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // trim copies and stored fine temperature
    logic [47:0] temp_trim_q;
    logic [63:0] press_low_q, press_mid_q;
    logic [15:0] press_high_q;
    logic signed [31:0] fine_temp_q;

    t_btc_result pending_results[$];
    int mismatch_count;
    int idle_cycles;
    bit hold_off;
    int hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sx32(longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    function automatic t_btc_result compensate_sample(logic kind, logic [RawW-1:0] raw);
        t_btc_result r;
        longint adc, t1, t2, t3, a, b, v1, v2, p, q, sum;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        r.kind = kind;
        r.temperature_centi = '0;
        r.pressure_q24_8 = '0;
        r.zero_divisor = 1'b0;
        adc = longint'(raw);
        if (kind == 1'b0) begin
            t1 = longint'(temp_trim_q[15:0]);
            t2 = longint'($signed(temp_trim_q[31:16]));
            t3 = longint'($signed(temp_trim_q[47:32]));
            a = (adc >>> 3) - 2 * t1;
            b = (adc >>> 4) - t1;
            v1 = asr64(sx32(a * t2), 11);
            v2 = asr64(sx32(b * b), 12);
            v2 = asr64(sx32(v2 * t3), 14);
            fine_temp_q = 32'(sx32(v1 + v2));
            r.temperature_centi = 32'(asr64(sx32(longint'(fine_temp_q) * 5 + 128), 8));
        end else begin
            p1 = longint'(press_low_q[15:0]);
            p2 = longint'($signed(press_low_q[31:16]));
            p3 = longint'($signed(press_low_q[47:32]));
            p4 = longint'($signed(press_low_q[63:48]));
            p5 = longint'($signed(press_mid_q[15:0]));
            p6 = longint'($signed(press_mid_q[31:16]));
            p7 = longint'($signed(press_mid_q[47:32]));
            p8 = longint'($signed(press_mid_q[63:48]));
            p9 = longint'($signed(press_high_q));
            v1 = longint'(fine_temp_q) - 128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) <<< 12);
            v1 = asr64(((64'sd1 <<< 47) + v1) * p1, 33);
            if (v1 == 0) begin
                r.zero_divisor = 1'b1;
                return r;
            end
            p = 1048576 - adc;
            p = ((p <<< 31) - v2) * 3125;
            // divide by minus one wraps instead of trapping
            if (v1 == -1) p = -p;
            else p = p / v1;
            q = asr64(p, 13);
            v1 = asr64(p9 * q * q, 25);
            v2 = asr64(p8 * p, 19);
            sum = asr64(p + v1 + v2, 8) + (p7 <<< 4);
            if (sum < 0) r.pressure_q24_8 = '0;
            else if (sum > 64'sh0000_0000_FFFF_FFFF) r.pressure_q24_8 = '1;
            else r.pressure_q24_8 = sum[31:0];
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_btc_result got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.kind = res_ch.result_kind;
            got.temperature_centi = res_ch.temperature_centi;
            got.pressure_q24_8 = res_ch.pressure_q24_8;
            got.zero_divisor = res_ch.zero_divisor;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d", got.kind);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind
                        || got.temperature_centi !== want.temperature_centi
                        || got.pressure_q24_8 !== want.pressure_q24_8
                        || got.zero_divisor !== want.zero_divisor) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp k=%0d t=%0d p=%h z=%0d got k=%0d t=%0d p=%h z=%0d",
                                 want.kind, want.temperature_centi, want.pressure_q24_8,
                                 want.zero_divisor, got.kind, got.temperature_centi,
                                 got.pressure_q24_8, got.zero_divisor);
                end
            end
        end
    end

    // receiver stall pattern, plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (hold_off) begin
            res_ch.ready <= 1'b0;
            hold_off_cycles <= 1500;
            hold_off <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    int burst_left;

    task automatic send_sample(logic kind, logic [RawW-1:0] raw);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.raw_sample <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(compensate_sample(kind, raw));
        burst_left--;
        if (burst_left == 0) in_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_trim(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_TEMP_TRIM:  temp_trim_q = value[47:0];
            CFG_PRESS_LOW:  press_low_q = value;
            CFG_PRESS_MID:  press_mid_q = value;
            default:        press_high_q = value[15:0];
        endcase
    endtask

    // typical factory coefficients
    task automatic load_typical_trim();
        write_trim(CFG_TEMP_TRIM, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
        write_trim(CFG_PRESS_LOW, {16'd2855, 16'hF05F, 16'd3024, 16'd36477} |
                                  ({48'd0, 16'hD67D} << 16));
        write_trim(CFG_PRESS_MID, {16'hF06F, 16'd15500, 16'hFFF9, 16'd140});
        write_trim(CFG_PRESS_HIGH, 64'd6000);
    endtask

    task automatic random_trim();
        write_trim(CFG_TEMP_TRIM, {$urandom, $urandom});
        write_trim(CFG_PRESS_LOW, {$urandom, $urandom});
        write_trim(CFG_PRESS_MID, {$urandom, $urandom});
        write_trim(CFG_PRESS_HIGH, {$urandom, $urandom});
    endtask

    task automatic test_reset_defaults();
        // pressure before any temperature uses zero fine temp, zero trims give zero divisor
        send_sample(1'b1, 20'd0);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        drain_results();
    endtask

    task automatic test_directed();
        load_typical_trim();
        send_sample(1'b1, 20'd415148);
        send_sample(1'b0, 20'd519888);
        send_sample(1'b1, 20'd415148);
        send_sample(1'b0, 20'd0);
        send_sample(1'b1, 20'd0);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        send_sample(1'b1, 20'h55555);
        send_sample(1'b1, 20'hAAAAA);
        drain_results();
        // extreme coefficients: overflow in both paths, saturation
        write_trim(CFG_TEMP_TRIM, {16'd0, 16'h8000, 16'h8000, 16'hFFFF});
        write_trim(CFG_PRESS_LOW, 64'h7FFF_8000_7FFF_FFFF);
        write_trim(CFG_PRESS_MID, 64'h8000_7FFF_8000_7FFF);
        write_trim(CFG_PRESS_HIGH, 64'h8000);
        send_sample(1'b0, 20'd0);
        send_sample(1'b1, 20'd0);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        drain_results();
        write_trim(CFG_TEMP_TRIM, {16'd0, 16'h7FFF, 16'h7FFF, 16'h0000});
        write_trim(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_0001);
        write_trim(CFG_PRESS_MID, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(CFG_PRESS_HIGH, 64'h7FFF);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'd12345);
        send_sample(1'b1, 20'hFFFFF);
        drain_results();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                drain_results();
                if ($urandom_range(0, 1)) load_typical_trim();
                else random_trim();
            end
            if ($urandom_range(0, 3) == 0)
                send_sample(1'b0, 20'($urandom_range(300000, 700000)));
            else if ($urandom_range(0, 9) == 0)
                send_sample(1'($urandom), 20'($urandom));
            else
                send_sample(1'b1, 20'($urandom_range(200000, 600000)));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        load_typical_trim();
        hold_off = 1'b1;
        burst_left = 30;
        for (int i = 0; i < 8; i++) send_sample(1'(i % 2), 20'($urandom));
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.raw_sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        temp_trim_q = '0;
        press_low_q = '0;
        press_mid_q = '0;
        press_high_q = '0;
        fine_temp_q = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        hold_off_cycles = 0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random(530);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
